### rtl/core/sdf_pkg.sv
package sdf_pkg;

    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIN_W      = 64;
    localparam int ACC_W      = BCD_W + BIN_W;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;

    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_SPACE = 8'h20;

    localparam logic [1:0] CFG_WIDTH = 2'd0;
    localparam logic [1:0] CFG_PREC  = 2'd1;
    localparam logic [1:0] CFG_FLAGS = 2'd2;
    localparam logic [1:0] CFG_SIZE  = 2'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    typedef struct packed {
        logic [BIN_W-1:0] mag;
        logic             has_sign;
        logic [7:0]       sign_char;
        logic             prec_given;
        logic [5:0]       prec;
        logic [6:0]       width;
        logic             left;
        logic             zfill;
    } t_job;

    // one double-dabble bit step: correct every digit, then shift in one binary bit
    function automatic logic [ACC_W-1:0] f_dabble(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0] tmp;
        tmp = acc;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (tmp[BIN_W + 4*i +: 4] >= 4'd5) begin
                tmp[BIN_W + 4*i +: 4] = tmp[BIN_W + 4*i +: 4] + 4'd3;
            end
        end
        return {tmp[ACC_W-2:0], 1'b0};
    endfunction

endpackage

### rtl/core/sdf_in_if.sv
interface sdf_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

### rtl/core/sdf_out_if.sv
interface sdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_last;
    logic [6:0] char_total;

    modport source (output valid, output out_char, output is_last, output char_total,
                    input ready);
    modport sink   (input valid, input out_char, input is_last, input char_total,
                    output ready);
endinterface

### rtl/core/sdf_front.sv
module sdf_front import sdf_pkg::*; #(
    parameter int MAX_FIELD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    sdf_in_if.sink     i_in,
    output logic       o_job_valid,
    input  logic       i_job_ready,
    output t_job       o_job
);

    logic [6:0] r_width;
    logic [6:0] r_prec;
    logic [3:0] r_flags;
    logic [1:0] r_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
            r_prec  <= 7'h7F;
            r_flags <= '0;
            r_size  <= SIZE_WORD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH: r_width <= i_cfg_data;
                CFG_PREC:  r_prec  <= i_cfg_data;
                CFG_FLAGS: r_flags <= i_cfg_data[3:0];
                CFG_SIZE:  r_size  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [63:0] v;
    logic        neg;
    logic        prec_given;

    always_comb begin
        case (r_size)
            SIZE_BYTE:  v = {{56{i_in.value[7]}}, i_in.value[7:0]};
            SIZE_HALF:  v = {{48{i_in.value[15]}}, i_in.value[15:0]};
            SIZE_WORD:  v = {{32{i_in.value[31]}}, i_in.value[31:0]};
            SIZE_DWORD: v = i_in.value;
            default:    v = i_in.value;
        endcase
        neg        = v[63];
        prec_given = !r_prec[6];

        o_job.mag        = neg ? (64'd0 - v) : v;
        o_job.has_sign   = neg || r_flags[0] || r_flags[3];
        o_job.sign_char  = neg ? C_MINUS : (r_flags[0] ? C_PLUS : C_SPACE);
        o_job.prec_given = prec_given;
        o_job.prec       = (r_prec[5:0] > 6'(MAX_FIELD - 1)) ? 6'(MAX_FIELD - 1)
                                                             : r_prec[5:0];
        o_job.width      = (r_width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : r_width;
        o_job.left       = r_flags[1];
        o_job.zfill      = r_flags[2] && !r_flags[1] && !prec_given;
    end

    assign o_job_valid = i_in.valid;
    assign i_in.ready  = i_job_ready;

endmodule

### rtl/core/sdf_queue.sv
module sdf_queue import sdf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_job i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_job o_rd_data
);

    localparam int DEPTH = 2;

    t_job       r_mem [DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic push;
    logic pop;

    assign o_wr_ready = (r_cnt != 2'(DEPTH));
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/sdf_back.sv
module sdf_back import sdf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    output logic o_job_ready,
    input  t_job i_job,
    sdf_out_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_LAY1 = 3'd2;
    localparam logic [2:0] S_LAY2 = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]       r_state;
    t_job             r_job;
    logic [ACC_W-1:0] r_acc;
    logic [3:0]       r_step;
    logic [6:0]       r_content;
    logic [6:0]       r_total;
    logic [6:0]       r_sp;
    logic [6:0]       r_ds;
    logic [6:0]       r_de;
    logic [6:0]       r_k;

    logic       r_ovalid;
    logic [7:0] r_char;
    logic       r_last;
    logic [6:0] r_ctotal;

    logic             out_free;
    logic [ACC_W-1:0] n_acc;
    logic [4:0]       hi;
    logic [6:0]       nrev;
    logic [6:0]       n_ndig;
    logic [6:0]       n_total;
    logic [6:0]       idx;
    logic [3:0]       digit;
    logic [7:0]       n_char;
    logic             emit_last;

    assign out_free     = !r_ovalid || o_out.ready;
    assign o_job_ready  = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.out_char   = r_char;
    assign o_out.is_last    = r_last;
    assign o_out.char_total = r_ctotal;

    always_comb begin
        n_acc = r_acc;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            n_acc = f_dabble(n_acc);
        end
    end

    // significant digit count and digit field length
    always_comb begin
        hi = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_acc[BIN_W + 4*i +: 4] != 4'd0) hi = 5'(i + 1);
        end
        if (hi != 5'd0)                                     nrev = {2'b00, hi};
        else if (r_job.prec_given && r_job.prec == 6'd0)    nrev = 7'd0;
        else                                                nrev = 7'd1;
        n_ndig = (r_job.prec_given && {1'b0, r_job.prec} > nrev) ? {1'b0, r_job.prec}
                                                                : nrev;
    end

    assign n_total = (r_content > r_job.width) ? r_content : r_job.width;

    // character at position r_k
    always_comb begin
        idx   = r_de - 7'd1 - r_k;
        digit = 4'd0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (idx == 7'(i)) digit = r_acc[BIN_W + 4*i +: 4];
        end
        if (r_k >= r_ds && r_k < r_de)             n_char = C_ZERO + {4'd0, digit};
        else if (r_job.has_sign && r_k == r_sp)    n_char = r_job.sign_char;
        else                                       n_char = C_SPACE;
        emit_last = (r_k == r_total - 7'd1);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_acc  <= {{BCD_W{1'b0}}, i_job.mag};
                r_step <= '0;
            end
            S_CONV: begin
                r_acc  <= n_acc;
                r_step <= r_step + 4'd1;
            end
            S_LAY1: begin
                r_content <= n_ndig + {6'd0, r_job.has_sign};
            end
            S_LAY2: begin
                r_total <= n_total;
                r_k     <= '0;
                if (r_job.left) begin
                    r_sp <= '0;
                    r_ds <= {6'd0, r_job.has_sign};
                    r_de <= r_content;
                end else if (r_job.zfill) begin
                    r_sp <= '0;
                    r_ds <= {6'd0, r_job.has_sign};
                    r_de <= n_total;
                end else begin
                    r_sp <= n_total - r_content;
                    r_ds <= n_total - r_content + {6'd0, r_job.has_sign};
                    r_de <= n_total;
                end
            end
            S_EMIT: begin
                if (out_free) r_k <= r_k + 7'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_job_valid) r_state <= S_CONV;
                S_CONV: if (r_step == 4'(CONV_STEPS - 1)) r_state <= S_LAY1;
                S_LAY1: r_state <= S_LAY2;
                S_LAY2: r_state <= (n_total == 7'd0) ? S_IDLE : S_EMIT;
                S_EMIT: if (out_free && emit_last) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register: hold while stalled, load one beat per free cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= (r_state == S_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_state == S_EMIT) begin
            r_char   <= n_char;
            r_last   <= emit_last;
            r_ctotal <= emit_last ? r_total : 7'd0;
        end
    end

endmodule

### rtl/core/signed_decimal_field_formatter.sv
// Signed decimal field formatter: printf "%d" text, one character per beat.
// i_in carries one 64-bit signed value per beat (valid/ready). o_out carries
// the characters of its field in order; is_last marks the final one, which
// also carries char_total. A field that comes out empty gives no beat.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data:
// index 0 field width, 1 precision (negative = not given), 2 flags
// (bit0 plus, bit1 left, bit2 zero, bit3 space), 3 operand size.
// The front classifies a value in the cycle it is taken and hands it to a
// two-entry queue, so up to two values are taken while a field is going out.
// The back converts to decimal with a double-dabble unit, 4 bits a cycle,
// works out the layout in states S_LAY1 and S_LAY2, then sends one character
// a cycle while the receiver keeps up; a field has up to MAX_FIELD
// characters, and the back takes no new value until its field is out. A
// stalled receiver holds the output register and the emitter; the queue
// then fills and i_in.ready drops.
// Reset returns the registers to width 0, precision not given, no flags and
// word size, and empties the queue and the emitter.
module signed_decimal_field_formatter import sdf_pkg::*; #(
    parameter int MAX_FIELD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    sdf_in_if.sink     i_in,
    sdf_out_if.source  o_out
);

    logic push_valid;
    logic push_ready;
    t_job push_job;
    logic pop_valid;
    logic pop_ready;
    t_job pop_job;

    sdf_front #(.MAX_FIELD(MAX_FIELD)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    sdf_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (push_valid),
        .o_wr_ready (push_ready),
        .i_wr_data  (push_job),
        .o_rd_valid (pop_valid),
        .i_rd_ready (pop_ready),
        .o_rd_data  (pop_job)
    );

    sdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_ready (pop_ready),
        .i_job       (pop_job),
        .o_out       (o_out)
    );

endmodule

### tb/sv/sdf_field_checker.sv
`timescale 1ns / 1ps

package sdf_tb_pkg;

    localparam logic [3:0] FLAG_PLUS  = 4'b0001;
    localparam logic [3:0] FLAG_LEFT  = 4'b0010;
    localparam logic [3:0] FLAG_ZERO  = 4'b0100;
    localparam logic [3:0] FLAG_SPACE = 4'b1000;

    // any value with bit 6 set means no precision
    localparam logic [6:0] PREC_NONE = 7'h7F;

endpackage

module sdf_field_checker import sdf_pkg::*; import sdf_tb_pkg::*; #(
    parameter int MAX_FIELD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    sdf_in_if          i_in,
    sdf_out_if         i_out,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_chars_checked
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [6:0] total;
    } t_field_char;

    logic [6:0] width_reg;
    logic [6:0] prec_reg;
    logic [3:0] flags_reg;
    logic [1:0] size_reg;

    t_field_char expected_chars[$];

    // queue the characters that printf %d would give for this value
    function automatic void format_field(input logic [63:0] raw);
        logic [63:0] v;
        logic [63:0] mag;
        logic [7:0]  sign_ch;
        logic [7:0]  digs [0:23];
        logic [7:0]  text [0:63];
        int          prec;
        int          wid;
        int          nd;
        int          ndig;
        int          content;
        int          total;
        int          pos;
        t_field_char ent;
        case (size_reg)
            SIZE_BYTE: v = {{56{raw[7]}}, raw[7:0]};
            SIZE_HALF: v = {{48{raw[15]}}, raw[15:0]};
            SIZE_WORD: v = {{32{raw[31]}}, raw[31:0]};
            default:   v = raw;
        endcase
        mag  = v[63] ? (64'd0 - v) : v;
        prec = prec_reg[6] ? -1 : int'(prec_reg);
        if (prec > MAX_FIELD - 1) prec = MAX_FIELD - 1;
        wid  = (int'(width_reg) > MAX_FIELD) ? MAX_FIELD : int'(width_reg);

        if (v[63])                         sign_ch = C_MINUS;
        else if ((flags_reg & FLAG_PLUS) != 0)  sign_ch = C_PLUS;
        else if ((flags_reg & FLAG_SPACE) != 0) sign_ch = C_SPACE;
        else                               sign_ch = 8'h00;

        nd = 0;
        if (!(mag == 64'd0 && prec == 0)) begin
            do begin
                digs[nd] = C_ZERO + 8'(mag % 64'd10);
                mag = mag / 64'd10;
                nd++;
            end while (mag != 64'd0 && nd < 24);
        end
        ndig    = (nd > prec) ? nd : prec;
        content = ndig + ((sign_ch != 8'h00) ? 1 : 0);
        total   = (content > wid) ? content : wid;
        if (total > MAX_FIELD) total = MAX_FIELD;
        if (total == 0) return;

        for (int k = 0; k < 64; k++) text[k] = C_SPACE;
        pos = 0;
        if ((flags_reg & FLAG_LEFT) != 0) begin
            // sign and digits first, trailing spaces already in place
        end else if ((flags_reg & FLAG_ZERO) != 0 && prec < 0) begin
            if (sign_ch != 8'h00) begin
                text[pos] = sign_ch;
                pos++;
            end
            while (pos < total - ndig) begin
                text[pos] = C_ZERO;
                pos++;
            end
            sign_ch = 8'h00;
        end else begin
            pos = total - content;
        end
        if (sign_ch != 8'h00) begin
            text[pos] = sign_ch;
            pos++;
        end
        for (int k = 0; k < ndig - nd; k++) begin
            text[pos] = C_ZERO;
            pos++;
        end
        for (int k = nd - 1; k >= 0; k--) begin
            text[pos] = digs[k];
            pos++;
        end

        for (int k = 0; k < total; k++) begin
            ent.ch    = text[k];
            ent.last  = (k == total - 1);
            ent.total = ent.last ? 7'(total) : 7'd0;
            expected_chars.push_back(ent);
        end
    endfunction

    always @(posedge i_clk) begin
        t_field_char want;
        if (!i_rst_n) begin
            width_reg = 7'd0;
            prec_reg  = PREC_NONE;
            flags_reg = 4'd0;
            size_reg  = SIZE_WORD;
            expected_chars.delete();
            o_fail_count    = 0;
            o_chars_checked = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH: width_reg = i_cfg_data;
                    CFG_PREC:  prec_reg  = i_cfg_data;
                    CFG_FLAGS: flags_reg = i_cfg_data[3:0];
                    CFG_SIZE:  size_reg  = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) format_field(i_in.value);
            if (i_out.valid && i_out.ready) begin
                o_chars_checked++;
                if (expected_chars.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected beat char %h last %b total %0d",
                             $time, i_out.out_char, i_out.is_last, i_out.char_total);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out.out_char !== want.ch) begin
                        o_fail_count++;
                        $display("%0t: out_char expected %h got %h",
                                 $time, want.ch, i_out.out_char);
                    end
                    if (i_out.is_last !== want.last) begin
                        o_fail_count++;
                        $display("%0t: is_last expected %b got %b",
                                 $time, want.last, i_out.is_last);
                    end
                    if (i_out.char_total !== want.total) begin
                        o_fail_count++;
                        $display("%0t: char_total expected %0d got %0d",
                                 $time, want.total, i_out.char_total);
                    end
                end
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

### tb/sv/signed_decimal_field_formatter_test.sv
`timescale 1ns / 1ps

module signed_decimal_field_formatter_test import sdf_pkg::*; import sdf_tb_pkg::*;;

    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_ITEMS  = 40;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_idx  = CFG_WIDTH;
    logic [6:0]  cfg_data = 7'd0;
    logic        tx_valid = 1'b0;
    logic [63:0] tx_value = 64'd0;
    logic        rx_ready = 1'b0;
    logic        out_fire = 1'b0;

    int fail_count;
    int pending_chars;
    int chars_checked;
    int n_values     = 0;
    int n_settings   = 0;
    int tx_max_gap   = 5;
    int rx_max_stall = 5;
    int rx_hold      = 0;
    int idle_cycles  = 0;

    sdf_in_if  in_ch();
    sdf_out_if out_ch();

    assign in_ch.valid  = tx_valid;
    assign in_ch.value  = tx_value;
    assign out_ch.ready = rx_ready;

    signed_decimal_field_formatter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    sdf_field_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending_chars),
        .o_chars_checked (chars_checked)
    );

    always #5 i_clk = ~i_clk;

    // receiver: draw a stall for every character beat
    always @(posedge i_clk) out_fire <= out_ch.valid && out_ch.ready;

    always @(negedge i_clk) begin
        if (out_fire) rx_hold = $urandom_range(0, rx_max_stall);
        if (rx_hold > 0) begin
            rx_ready <= 1'b0;
            rx_hold--;
        end else begin
            rx_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("signed_decimal_field_formatter_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [6:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // hold the input until every queued character is out, then let empty fields finish
    task automatic wait_drained();
        @(negedge i_clk);
        tx_valid <= 1'b0;
        while (pending_chars != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_format(input logic [6:0] w, input logic [6:0] p,
                              input logic [3:0] f, input logic [1:0] s);
        wait_drained();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_PREC, p);
        cfg_write(CFG_FLAGS, {3'd0, f});
        cfg_write(CFG_SIZE, {5'd0, s});
        n_settings++;
    endtask

    task automatic send_value(input logic [63:0] v);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            @(negedge i_clk);
            tx_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        tx_valid <= 1'b1;
        tx_value <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_values++;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0]        r;
        logic [63:0]        mask;
        logic signed [63:0] sv;
        int                 s;
        int                 bits;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: return r;
            2: begin
                s  = int'($urandom_range(0, 2000)) - 1000;
                sv = 64'(s);
                return sv;
            end
            3: return 64'($urandom_range(0, 9));
            4: begin
                // size boundaries with junk above the kept bits
                bits = 8 << $urandom_range(0, 3);
                mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
                case ($urandom_range(0, 2))
                    0: return (r & ~mask) | (mask >> 1);
                    1: return (r & ~mask) | (64'd1 << (bits - 1));
                    default: return r | mask;
                endcase
            end
            default: return r;
        endcase
    endfunction

    initial begin
        logic [6:0] w;
        logic [6:0] p;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: width 0, no precision, no flags, word size
        send_value(64'd0);
        send_value(64'd1);
        send_value(-64'sd1);
        send_value(64'h1234_5678_9ABC_DEF0);
        send_value(64'hFFFF_FFFF_8000_0000);

        set_format(7'd0, PREC_NONE, 4'd0, SIZE_DWORD);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);

        // zero with precision zero and no width gives nothing
        set_format(7'd0, 7'd0, 4'd0, SIZE_BYTE);
        send_value(64'hFFFF_FFFF_FFFF_FF00);
        send_value(64'h80);
        send_value(64'h7F);

        set_format(7'd6, 7'd0, FLAG_PLUS | FLAG_SPACE, SIZE_HALF);
        send_value(64'd0);
        send_value(64'h8000);

        set_format(7'd10, 7'd3, FLAG_LEFT | FLAG_ZERO, SIZE_WORD);
        send_value(64'd5);
        send_value(-64'sd42);

        set_format(7'd10, 7'd4, FLAG_ZERO | FLAG_SPACE, SIZE_WORD);
        send_value(64'd7);
        send_value(-64'sd7);

        set_format(7'd12, PREC_NONE, FLAG_ZERO, SIZE_DWORD);
        send_value(-64'sd123);
        send_value(64'd123);

        // width past the limit and the longest precision
        set_format(7'd127, 7'd63, FLAG_PLUS, SIZE_DWORD);
        send_value(64'd1);
        send_value(-64'sd1);

        set_format(7'd64, 7'h40, FLAG_LEFT | FLAG_SPACE, SIZE_BYTE);
        send_value(64'd3);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       w = 7'd0;
                1:       w = 7'($urandom_range(65, 127));
                2:       w = 7'd64;
                default: w = 7'($urandom_range(1, 20));
            endcase
            case ($urandom_range(0, 5))
                0, 1:    p = PREC_NONE;
                2:       p = 7'($urandom_range(64, 126));
                3:       p = 7'($urandom_range(30, 63));
                default: p = 7'($urandom_range(0, 10));
            endcase
            set_format(w, p, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: begin tx_max_gap = 0; rx_max_stall = 0; end
                1: begin tx_max_gap = 5; rx_max_stall = 0; end
                2: begin tx_max_gap = 0; rx_max_stall = 5; end
                default: begin tx_max_gap = 5; rx_max_stall = 5; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 3 && i == PHASE_ITEMS / 2) wait_drained();
                send_value(pick_value());
            end
        end

        wait_drained();
        $display("formatted %0d values under %0d register settings,", n_values, n_settings);
        $display("%0d characters compared against prediction", chars_checked);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("signed_decimal_field_formatter_test: done, clean");
        end else begin
            $display("signed_decimal_field_formatter_test: done, errors");
        end
        $finish;
    end

endmodule
